// ===== src/gated_pulse_counter_min_median_max_defines.svh =====
// ----------------------------------------------------------------------------
// Gated pulse counter assertion macros
// Shared concurrent assertion forms used by the counter's RTL.
// ----------------------------------------------------------------------------
`ifndef GATED_PULSE_COUNTER_MIN_MEDIAN_MAX_DEFINES_SVH
`define GATED_PULSE_COUNTER_MIN_MEDIAN_MAX_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPCMM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPCMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/gpcmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Gated pulse counter package
// Widths, register codes and the structs passed between the counter's modules.
// ----------------------------------------------------------------------------
package gpcmm_pkg;

   localparam int MAX_SAMPLES = 16;
   localparam int COUNT_W     = 32;
   localparam int GATE_W      = 32;
   localparam int SAMPLES_W   = 5;
   localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int FILL_W      = $clog2(MAX_SAMPLES + 1);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [GATE_W-1:0]    GATE_TICKS_RESET   = GATE_W'(1000000);
   localparam logic [SAMPLES_W-1:0] SAMPLE_COUNT_RESET = SAMPLES_W'(9);

   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GATE_TICKS   = 2'd0,
      CSR_SAMPLE_COUNT = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   typedef struct packed {
      logic insert;
      logic shift;
      logic occupied;
      logic at_end;
   } cell_ctrl_type;

   typedef struct packed {
      logic      gt;
      count_type value;
   } cell_link_type;

   typedef struct packed {
      logic      close;
      count_type count;
   } window_type;

endpackage

// ===== src/gpcmm_intf.sv =====
// ----------------------------------------------------------------------------
// Gated pulse counter channel interfaces
// Valid/ready channels for ticks, reports and register writes.
// ----------------------------------------------------------------------------
interface gpcmm_req_if;
   logic valid;
   logic ready;
   logic signal_level;

   modport source (output valid, output signal_level, input ready);
   modport sink (input valid, input signal_level, output ready);
endinterface

interface gpcmm_rsp_if;
   import gpcmm_pkg::*;
   logic      valid;
   logic      ready;
   count_type min_count;
   count_type median_count;
   count_type max_count;

   modport source (output valid, output min_count, output median_count,
                   output max_count, input ready);
   modport sink (input valid, input min_count, input median_count,
                 input max_count, output ready);
endinterface

interface gpcmm_csr_if;
   import gpcmm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/gpcmm_cell.sv =====
// ----------------------------------------------------------------------------
// Gated pulse counter sort cell
// One slot of the sorted count chain: insert with shift up, drain downward.
// ----------------------------------------------------------------------------
module gpcmm_cell (
   input  logic                      clock,
   input  gpcmm_pkg::cell_ctrl_type  ctrl,
   input  gpcmm_pkg::count_type      new_value,
   input  gpcmm_pkg::cell_link_type  prev_link,
   input  gpcmm_pkg::count_type      next_value,
   output gpcmm_pkg::cell_link_type  link
);
   import gpcmm_pkg::*;

   count_type value_ff;
   count_type value_in;
   logic      gt;

   always_comb begin
      gt         = ctrl.occupied && (value_ff > new_value);
      link.gt    = gt;
      link.value = value_ff;
   end

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (prev_link.gt) begin
            value_in = prev_link.value;
         end else if (gt || ctrl.at_end) begin
            value_in = new_value;
         end
      end else if (ctrl.shift) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ===== src/gpcmm_window.sv =====
// ----------------------------------------------------------------------------
// Gated pulse counter gate window
// Counts falling edges over a window of ticks and flags the closing tick.
// ----------------------------------------------------------------------------
module gpcmm_window (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         tick,
   input  logic                         level,
   input  logic [gpcmm_pkg::GATE_W-1:0] gate_ticks,
   output gpcmm_pkg::window_type        win
);
   import gpcmm_pkg::*;

   logic              prev_ff;
   logic [GATE_W-1:0] elapsed_ff;
   count_type         edge_ff;
   logic [GATE_W-1:0] elapsed_next;
   logic [GATE_W-1:0] gate_eff;
   count_type         edge_next;
   logic              close;

   always_comb begin
      edge_next = edge_ff;
      if (prev_ff && !level && (edge_ff != '1)) begin
         edge_next = edge_ff + COUNT_W'(1);
      end
      elapsed_next = elapsed_ff;
      if (elapsed_ff != '1) begin
         elapsed_next = elapsed_ff + GATE_W'(1);
      end
      gate_eff  = (gate_ticks == '0) ? GATE_W'(1) : gate_ticks;
      close     = (elapsed_next >= gate_eff);
      win.close = tick && close;
      win.count = edge_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff    <= 1'b0;
         elapsed_ff <= '0;
         edge_ff    <= '0;
      end else if (tick) begin
         prev_ff <= level;
         if (close) begin
            elapsed_ff <= '0;
            edge_ff    <= '0;
         end else begin
            elapsed_ff <= elapsed_next;
            edge_ff    <= edge_next;
         end
      end
   end

endmodule

// ===== src/gated_pulse_counter_min_median_max.sv =====
// ----------------------------------------------------------------------------
// Gated pulse counter with min / median / max report
// Counts falling edges per gate window, sorts the window counts and reports
// the smallest, the middle and the largest count of each set.
// ----------------------------------------------------------------------------
// The block takes one tick per cycle. Each window count is inserted into a
// chain of sorted cells. When a set of n windows is complete the chain is
// drained toward its head, and no tick is taken while it drains. A finished
// report waits in the output register while ticks go on.
module gated_pulse_counter_min_median_max (
   input logic        clock,
   input logic        reset,
   gpcmm_req_if.sink  req_bus,
   gpcmm_rsp_if.source rsp_bus,
   gpcmm_csr_if.sink  csr_bus
);
   import gpcmm_pkg::*;

   `include "gated_pulse_counter_min_median_max_defines.svh"

   logic [GATE_W-1:0]    gate_ticks_ff;
   logic [SAMPLES_W-1:0] sample_count_ff;
   state_type            state_ff, state_in;
   logic [FILL_W-1:0]    windows_done_ff, windows_done_in;
   logic [IDX_W-1:0]     step_ff, step_in;
   count_type            min_acc_ff, med_acc_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   count_type            min_out_ff, med_out_ff, max_out_ff;
   count_type            min_out_in, med_out_in, max_out_in;

   logic                           tick;
   window_type                     win;
   logic [FILL_W-1:0]              fill_next;
   logic [FILL_W-1:0]              eff_samples;
   logic [SAMPLES_W+FILL_W-1:0]    sc_ext;
   logic                           out_free;
   logic                           draining;
   logic                           drain_first, drain_med, drain_last;
   logic                           shift;
   count_type                      head_value;
   cell_ctrl_type                  cell_ctrl [MAX_SAMPLES];
   cell_link_type                  links [MAX_SAMPLES];

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ticks_ff   <= GATE_TICKS_RESET;
         sample_count_ff <= SAMPLE_COUNT_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_GATE_TICKS: begin
               gate_ticks_ff <= csr_bus.data[GATE_W-1:0];
            end
            CSR_SAMPLE_COUNT: begin
               sample_count_ff <= csr_bus.data[SAMPLES_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sc_ext = {{FILL_W{1'b0}}, sample_count_ff};
      if (sample_count_ff == '0) begin
         eff_samples = FILL_W'(1);
      end else if (sc_ext > (SAMPLES_W + FILL_W)'(MAX_SAMPLES)) begin
         eff_samples = FILL_W'(MAX_SAMPLES);
      end else begin
         eff_samples = sc_ext[FILL_W-1:0];
      end
   end

   assign req_bus.ready = (state_ff == ST_RUN);
   assign tick          = req_bus.valid && req_bus.ready;

   gpcmm_window u_window (
      .clock      (clock),
      .reset      (reset),
      .tick       (tick),
      .level      (req_bus.signal_level),
      .gate_ticks (gate_ticks_ff),
      .win        (win)
   );

   assign head_value  = links[0].value;
   assign fill_next   = windows_done_ff + FILL_W'(1);
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign draining    = (state_ff == ST_DRAIN);
   assign drain_first = (step_ff == '0);
   assign drain_med   = (FILL_W'(step_ff) == (windows_done_ff >> 1));
   assign drain_last  = (FILL_W'(step_ff) == (windows_done_ff - FILL_W'(1)));
   assign shift       = draining && !(drain_last && !out_free);

   for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
      assign cell_ctrl[i].insert   = win.close;
      assign cell_ctrl[i].shift    = shift;
      assign cell_ctrl[i].occupied = (FILL_W'(i) < windows_done_ff);
      assign cell_ctrl[i].at_end   = (FILL_W'(i) == windows_done_ff);

      if (i == 0) begin : g_head
         if (MAX_SAMPLES == 1) begin : g_single
            gpcmm_cell u_cell (
               .clock      (clock),
               .ctrl       (cell_ctrl[i]),
               .new_value  (win.count),
               .prev_link  ('0),
               .next_value (links[i].value),
               .link       (links[i])
            );
         end else begin : g_first
            gpcmm_cell u_cell (
               .clock      (clock),
               .ctrl       (cell_ctrl[i]),
               .new_value  (win.count),
               .prev_link  ('0),
               .next_value (links[i+1].value),
               .link       (links[i])
            );
         end
      end else if (i == MAX_SAMPLES - 1) begin : g_tail
         gpcmm_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl[i]),
            .new_value  (win.count),
            .prev_link  (links[i-1]),
            .next_value (links[i].value),
            .link       (links[i])
         );
      end else begin : g_mid
         gpcmm_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl[i]),
            .new_value  (win.count),
            .prev_link  (links[i-1]),
            .next_value (links[i+1].value),
            .link       (links[i])
         );
      end
   end

   always_comb begin
      state_in        = state_ff;
      windows_done_in = windows_done_ff;
      step_in         = step_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      min_out_in      = min_out_ff;
      med_out_in      = med_out_ff;
      max_out_in      = max_out_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (win.close) begin
               windows_done_in = fill_next;
               step_in         = '0;
               if (fill_next >= eff_samples) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (drain_last) begin
               if (out_free) begin
                  rsp_valid_in    = 1'b1;
                  min_out_in      = drain_first ? head_value : min_acc_ff;
                  med_out_in      = drain_med ? head_value : med_acc_ff;
                  max_out_in      = head_value;
                  windows_done_in = '0;
                  state_in        = ST_RUN;
               end
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_RUN;
         windows_done_ff <= '0;
         step_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         windows_done_ff <= windows_done_in;
         step_ff         <= step_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      min_out_ff <= min_out_in;
      med_out_ff <= med_out_in;
      max_out_ff <= max_out_in;
      if (draining && drain_first) begin
         min_acc_ff <= head_value;
      end
      if (draining && drain_med) begin
         med_acc_ff <= head_value;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.min_count    = min_out_ff;
   assign rsp_bus.median_count = med_out_ff;
   assign rsp_bus.max_count    = max_out_ff;

   `GPCMM_ASSERT_SAME(a_no_tick_in_drain, clock, reset, state_ff == ST_DRAIN, !req_bus.ready, "tick port open while draining")
   `GPCMM_ASSERT_SAME(a_fill_bound, clock, reset, 1'b1, windows_done_ff <= FILL_W'(MAX_SAMPLES), "window fill count above capacity")
   `GPCMM_ASSERT_NEXT(a_set_full, clock, reset, win.close && (fill_next >= eff_samples), (state_ff == ST_DRAIN) && (step_ff == '0), "full set did not start draining")
   `GPCMM_ASSERT_NEXT(a_report_done, clock, reset, draining && drain_last && out_free, rsp_valid_ff && (state_ff == ST_RUN) && (windows_done_ff == '0), "drain end did not post a report item")

endmodule
